// ===== rtl/bcdb_pkg.sv =====
// bcdb_pkg: shared widths, debounce constants and event codes for the
// button/card debounce and LED blinker block
// no dependencies

package bcdb_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int HIST_W     = 16;
    localparam int EVENT_W    = 2;

    // scan period in ms: histories shift when more than this has passed
    localparam logic [TIME_W-1:0] SCAN_PERIOD = TIME_W'(7);

    // history patterns
    localparam logic [HIST_W-1:0] HIST_ALL_ONES  = 16'hFFFF;
    localparam logic [HIST_W-1:0] HIST_ALL_ZEROS = 16'h0000;
    localparam logic [HIST_W-1:0] PRESS_PATTERN  = 16'h000F;
    localparam logic [HIST_W-1:0] PRESS_MASK     = 16'hF00F;

    // card event codes
    typedef enum logic [EVENT_W-1:0] {
        CARD_NONE     = 2'd0,
        CARD_INSERTED = 2'd1,
        CARD_REMOVED  = 2'd2
    } card_event_t;

endpackage

// ===== rtl/bcdb_channels.sv =====
// bcdb_poll_if and bcdb_result_if: valid/ready channels for poll items and
// result items
// depends on bcdb_pkg

interface bcdb_poll_if;
    logic                         valid;
    logic                         ready;
    logic [bcdb_pkg::TIME_W-1:0]  now_ms;
    logic                         button_level;
    logic                         card_detect_level;

    modport source (output valid, now_ms, button_level, card_detect_level, input ready);
    modport sink   (input valid, now_ms, button_level, card_detect_level, output ready);
endinterface

interface bcdb_result_if;
    logic                          valid;
    logic                          ready;
    logic                          led_on;
    logic                          button_press;
    logic [bcdb_pkg::EVENT_W-1:0]  card_event;
    logic                          card_present;

    modport source (output valid, led_on, button_press, card_event, card_present,
                    input ready);
    modport sink   (input valid, led_on, button_press, card_event, card_present,
                    output ready);
endinterface

// ===== rtl/button_card_debounce_blinker.sv =====
// button_card_debounce_blinker: polled button/card-detect debouncer with LED blinker
// depends on bcdb_pkg and the channel interfaces in bcdb_channels.sv

// One poll item is accepted per clock cycle while the result side keeps up. The poll
// is captured in an input register, then the debounce, scan and blink update runs
// against the state registers and lands in the result register, which offers it.
// Throughput is set by that single update stage; the only stall comes from the result
// side holding ready low, and even then the input register takes one more item while
// the result waits. The user must write blink_interval through cfg_we/cfg_wdata only
// while no item is in flight; the block itself does not enforce this.

module button_card_debounce_blinker (
    input  logic                              clk,
    input  logic                              rst_n,
    bcdb_poll_if.sink                         poll,
    bcdb_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [bcdb_pkg::INTERVAL_W-1:0]   cfg_wdata
);

    // input stage
    logic                          s1_valid_reg;
    logic [bcdb_pkg::TIME_W-1:0]   s1_now_reg;
    logic                          s1_btn_reg;
    logic                          s1_cd_reg;

    // block state
    logic [bcdb_pkg::INTERVAL_W-1:0] blink_interval_reg;
    logic [bcdb_pkg::TIME_W-1:0]     last_scan_reg;
    logic [bcdb_pkg::TIME_W-1:0]     last_toggle_reg;
    logic [bcdb_pkg::HIST_W-1:0]     btn_hist_reg;
    logic [bcdb_pkg::HIST_W-1:0]     card_hist_reg;
    logic                            held_reg;
    logic                            card_seen_reg;
    logic                            led_reg;

    // result register
    logic                          out_valid_reg;
    logic                          out_press_reg;
    bcdb_pkg::card_event_t         out_event_reg;

    // next values
    logic [bcdb_pkg::TIME_W-1:0]   toggle_delta;
    logic [bcdb_pkg::TIME_W-1:0]   scan_delta;
    logic                          toggle;
    logic                          scan;
    logic                          led_next;
    logic                          held_next;
    logic [bcdb_pkg::HIST_W-1:0]   btn_hist_next;
    logic [bcdb_pkg::HIST_W-1:0]   card_hist_next;
    logic                          card_seen_next;
    logic                          press_next;
    bcdb_pkg::card_event_t         event_next;

    // handshake
    logic s2_adv;
    logic poll_acc;

    assign s2_adv   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !s1_valid_reg || s2_adv;
    assign poll_acc = poll.valid && poll.ready;

    // blink decision, wrapping time difference
    assign toggle_delta = s1_now_reg - last_toggle_reg;
    assign toggle = (blink_interval_reg != '0)
                    && (toggle_delta >= {{(bcdb_pkg::TIME_W - bcdb_pkg::INTERVAL_W){1'b0}},
                                          blink_interval_reg});
    assign led_next = toggle ? !led_reg : led_reg;

    // held flag from the history before this poll
    always_comb
    begin
        held_next = held_reg;
        priority if (btn_hist_reg == bcdb_pkg::HIST_ALL_ONES)
        begin
            held_next = 1'b1;
        end
        else if (btn_hist_reg == bcdb_pkg::HIST_ALL_ZEROS)
        begin
            held_next = 1'b0;
        end
    end

    // scan: shift histories, detect press and card changes
    assign scan_delta = s1_now_reg - last_scan_reg;
    assign scan = scan_delta > bcdb_pkg::SCAN_PERIOD;

    always_comb
    begin
        btn_hist_next  = btn_hist_reg;
        card_hist_next = card_hist_reg;
        card_seen_next = card_seen_reg;
        press_next     = 1'b0;
        event_next     = bcdb_pkg::CARD_NONE;
        if (scan)
        begin
            btn_hist_next  = {btn_hist_reg[bcdb_pkg::HIST_W-2:0], s1_btn_reg};
            card_hist_next = {card_hist_reg[bcdb_pkg::HIST_W-2:0], !s1_cd_reg};
            press_next = !held_next
                         && ((btn_hist_next & bcdb_pkg::PRESS_MASK) == bcdb_pkg::PRESS_PATTERN);
            priority if (!card_seen_reg && card_hist_next == bcdb_pkg::HIST_ALL_ONES)
            begin
                card_seen_next = 1'b1;
                event_next     = bcdb_pkg::CARD_INSERTED;
            end
            else if (card_seen_reg && card_hist_next == bcdb_pkg::HIST_ALL_ZEROS)
            begin
                card_seen_next = 1'b0;
                event_next     = bcdb_pkg::CARD_REMOVED;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            s1_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_acc)
        begin
            s1_now_reg <= poll.now_ms;
            s1_btn_reg <= poll.button_level;
            s1_cd_reg  <= poll.card_detect_level;
        end
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_interval_reg <= '0;
        end
        else if (cfg_we)
        begin
            blink_interval_reg <= cfg_wdata;
        end
    end

    // state update and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_scan_reg   <= '0;
            last_toggle_reg <= '0;
            btn_hist_reg    <= '0;
            card_hist_reg   <= '0;
            held_reg        <= 1'b0;
            card_seen_reg   <= 1'b0;
            led_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_press_reg   <= 1'b0;
            out_event_reg   <= bcdb_pkg::CARD_NONE;
        end
        else
        begin
            if (s2_adv)
            begin
                if (toggle)
                begin
                    last_toggle_reg <= s1_now_reg;
                end
                if (scan)
                begin
                    last_scan_reg <= s1_now_reg;
                end
                btn_hist_reg  <= btn_hist_next;
                card_hist_reg <= card_hist_next;
                held_reg      <= held_next;
                card_seen_reg <= card_seen_next;
                led_reg       <= led_next;
                out_press_reg <= press_next;
                out_event_reg <= event_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result channel
    assign result.valid        = out_valid_reg;
    assign result.led_on       = led_reg;
    assign result.button_press = out_press_reg;
    assign result.card_event   = out_event_reg;
    assign result.card_present = card_seen_reg;

endmodule

// ===== rtl/bcdb_checker.sv =====
// bcdb_checker: port-level assertions for button_card_debounce_blinker,
// attached to the top level by the bind at the end of this file
// depends on bcdb_pkg

module bcdb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_valid,
    input  logic                           res_ready,
    input  logic                           led_on,
    input  logic                           button_press,
    input  logic [bcdb_pkg::EVENT_W-1:0]   card_event,
    input  logic                           card_present
);

    logic last_present_reg;
    logic res_acc;

    assign res_acc = res_valid && res_ready;

    // card presence seen on the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_present_reg <= 1'b0;
        end
        else if (res_acc)
        begin
            last_present_reg <= card_present;
        end
    end

    // stalled item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    // stalled item keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(led_on) && $stable(button_press)
                                    && $stable(card_event) && $stable(card_present))
        else $error("result payload changed while stalled");

    // insert and remove events agree with the presence flag
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && card_event != bcdb_pkg::CARD_NONE |->
            (card_event == bcdb_pkg::CARD_INSERTED && card_present)
            || (card_event == bcdb_pkg::CARD_REMOVED && !card_present))
        else $error("card event does not match card presence");

    // presence only changes together with an event
    assert property (@(posedge clk) disable iff (!rst_n)
        res_acc && card_event == bcdb_pkg::CARD_NONE |-> card_present == last_present_reg)
        else $error("card presence changed without an event");

endmodule

bind button_card_debounce_blinker bcdb_checker u_bcdb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .led_on       (result.led_on),
    .button_press (result.button_press),
    .card_event   (result.card_event),
    .card_present (result.card_present)
);

// ===== dv/tb_button_card_debounce_blinker.sv =====
// tb_button_card_debounce_blinker: self-checking bench for the button/card debounce and
// led blinker, with its own poll predictor, random idling on both channels and a watchdog
// depends on bcdb_pkg, bcdb_channels.sv and button_card_debounce_blinker.sv

module tb_button_card_debounce_blinker;

    // cycles with no item moving on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 500;

    typedef struct packed {
        logic                  led_on;
        logic                  button_press;
        bcdb_pkg::card_event_t card_event;
        logic                  card_present;
    } poll_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [bcdb_pkg::INTERVAL_W-1:0] cfg_wdata;

    bcdb_poll_if   poll_ch ();
    bcdb_result_if res_ch ();

    button_card_debounce_blinker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state, mirrors the block after reset
    logic [bcdb_pkg::INTERVAL_W-1:0] blink_ms       = '0;
    logic [bcdb_pkg::TIME_W-1:0]     last_scan_ms   = '0;
    logic [bcdb_pkg::TIME_W-1:0]     last_toggle_ms = '0;
    logic [bcdb_pkg::HIST_W-1:0]     btn_hist       = '0;
    logic [bcdb_pkg::HIST_W-1:0]     card_hist      = '0;
    logic                            btn_held       = 1'b0;
    logic                            card_in        = 1'b0;
    logic                            led_state      = 1'b0;

    poll_result_t poll_outcomes[$];
    logic [bcdb_pkg::TIME_W-1:0] clock_ms = '0;
    bit idle_on = 1'b0;
    int mismatches = 0;
    int polls_sent = 0;
    int results_seen = 0;
    int presses = 0;
    int inserts = 0;
    int removes = 0;
    int toggles = 0;
    int settings = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    // clock
    always
    begin
        #5 clk <= 1'b1;
        #5 clk <= 1'b0;
    end

    // one poll: blink, held flag from the old history, then scan and events
    function automatic poll_result_t debounce_poll(logic [bcdb_pkg::TIME_W-1:0] t,
                                                   logic btn, logic cd);
        poll_result_t r;
        logic [bcdb_pkg::TIME_W-1:0] since_toggle;
        logic [bcdb_pkg::TIME_W-1:0] since_scan;
        since_toggle = t - last_toggle_ms;
        since_scan = t - last_scan_ms;
        r.button_press = 1'b0;
        r.card_event = bcdb_pkg::CARD_NONE;
        if (blink_ms != '0 && since_toggle >= bcdb_pkg::TIME_W'(blink_ms))
        begin
            last_toggle_ms = t;
            led_state = ~led_state;
            toggles++;
        end
        if (btn_hist == bcdb_pkg::HIST_ALL_ONES)
            btn_held = 1'b1;
        else if (btn_hist == bcdb_pkg::HIST_ALL_ZEROS)
            btn_held = 1'b0;
        if (since_scan > bcdb_pkg::SCAN_PERIOD)
        begin
            last_scan_ms = t;
            btn_hist = {btn_hist[bcdb_pkg::HIST_W-2:0], btn};
            card_hist = {card_hist[bcdb_pkg::HIST_W-2:0], ~cd};
            if (!btn_held && (btn_hist & bcdb_pkg::PRESS_MASK) == bcdb_pkg::PRESS_PATTERN)
            begin
                r.button_press = 1'b1;
                presses++;
            end
            if (!card_in && card_hist == bcdb_pkg::HIST_ALL_ONES)
            begin
                card_in = 1'b1;
                r.card_event = bcdb_pkg::CARD_INSERTED;
                inserts++;
            end
            else if (card_in && card_hist == bcdb_pkg::HIST_ALL_ZEROS)
            begin
                card_in = 1'b0;
                r.card_event = bcdb_pkg::CARD_REMOVED;
                removes++;
            end
        end
        r.led_on = led_state;
        r.card_present = card_in;
        return r;
    endfunction

    // send one poll item, with an occasional gap before it
    task automatic send_poll(input logic [bcdb_pkg::TIME_W-1:0] t, input logic btn,
                             input logic cd);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid <= 1'b1;
        poll_ch.now_ms <= t;
        poll_ch.button_level <= btn;
        poll_ch.card_detect_level <= cd;
        @(posedge clk);
        while (!poll_ch.ready)
            @(posedge clk);
        clock_ms = t;
        poll_outcomes.push_back(debounce_poll(t, btn, cd));
        polls_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic wait_idle();
        poll_ch.valid <= 1'b0;
        while (poll_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // write the blink interval while nothing is in flight
    task automatic set_blink(input logic [bcdb_pkg::INTERVAL_W-1:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        blink_ms = v;
        settings++;
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on result %0d: %s expected %0d got %0d",
                     results_seen, what, want, got);
    endtask

    // compare one result item with the oldest prediction
    task automatic check_result();
        poll_result_t want;
        if (poll_outcomes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result item %0d arrived with no poll pending", results_seen);
        end
        else
        begin
            want = poll_outcomes.pop_front();
            if (res_ch.led_on !== want.led_on)
                flag_mismatch("led_on", want.led_on, res_ch.led_on);
            if (res_ch.button_press !== want.button_press)
                flag_mismatch("button_press", want.button_press, res_ch.button_press);
            if (res_ch.card_event !== want.card_event)
                flag_mismatch("card_event", want.card_event, res_ch.card_event);
            if (res_ch.card_present !== want.card_present)
                flag_mismatch("card_present", want.card_present, res_ch.card_present);
        end
        results_seen++;
    endtask

    // result side: check accepted items, stall in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (!rst_n || (poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // scan threshold, wrapped and backwards time, field extremes
    task automatic test_scan_timing();
        send_poll(32'd0, 1'b0, 1'b1);
        send_poll(32'd7, 1'b1, 1'b0);
        send_poll(32'd8, 1'b1, 1'b0);
        send_poll(32'd15, 1'b0, 1'b1);
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_poll(32'hFFFF_FFF0, 1'b0, 1'b0);
        send_poll(32'd0, 1'b0, 1'b1);
    endtask

    // four low scans then four high scans give one press
    task automatic test_press_detect();
        repeat (4) send_poll(clock_ms + 10, 1'b0, 1'b1);
        repeat (4) send_poll(clock_ms + 10, 1'b1, 1'b1);
    endtask

    // smallest and largest interval, exact boundary, then blinking off
    task automatic test_blink_interval();
        logic [bcdb_pkg::TIME_W-1:0] base;
        set_blink(16'd1);
        send_poll(clock_ms + 1, 1'b1, 1'b0);
        send_poll(clock_ms, 1'b0, 1'b0);
        send_poll(clock_ms + 1, 1'b1, 1'b1);
        set_blink(16'hFFFF);
        base = clock_ms;
        send_poll(base + 100, 1'b0, 1'b1);
        send_poll(base + 65534, 1'b1, 1'b0);
        send_poll(base + 65535, 1'b0, 1'b1);
        set_blink(16'd0);
        send_poll(clock_ms + 100000, 1'b1, 1'b0);
        send_poll(clock_ms + 5, 1'b0, 1'b1);
    endtask

    // mostly steady level runs with glitches, some raw noise and time jumps
    task automatic test_random_traffic();
        logic [bcdb_pkg::INTERVAL_W-1:0] interval;
        logic btn_lvl;
        logic card_lvl;
        logic btn;
        logic cd;
        int unsigned btn_left;
        int unsigned card_left;
        logic [bcdb_pkg::TIME_W-1:0] step;
        btn_lvl = 1'b0;
        card_lvl = 1'b0;
        btn_left = 0;
        card_left = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: interval = bcdb_pkg::INTERVAL_W'($urandom_range(2, 300));
                1: interval = 16'd1;
                2: interval = 16'hFFFF;
                3: interval = bcdb_pkg::INTERVAL_W'($urandom);
                default: interval = bcdb_pkg::INTERVAL_W'($urandom_range(10, 60));
            endcase
            idle_on = (phase < 4);
            set_blink(interval);
            for (int i = 0; i < 104; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    if (btn_left == 0)
                    begin
                        btn_lvl = ~btn_lvl;
                        btn_left = $urandom_range(2, 30);
                    end
                    if (card_left == 0)
                    begin
                        card_lvl = ~card_lvl;
                        card_left = $urandom_range(4, 45);
                    end
                    btn_left--;
                    card_left--;
                    btn = btn_lvl ^ ($urandom_range(0, 19) == 0);
                    cd = ~card_lvl ^ ($urandom_range(0, 39) == 0);
                    case ($urandom_range(0, 9))
                        7, 8: step = $urandom_range(0, 7);
                        9: step = $urandom_range(26, 400);
                        default: step = $urandom_range(8, 25);
                    endcase
                end
                else
                begin
                    btn = 1'($urandom);
                    cd = 1'($urandom);
                    step = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20);
                end
                send_poll(clock_ms + step, btn, cd);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        poll_ch.valid = 1'b0;
        poll_ch.now_ms = '0;
        poll_ch.button_level = 1'b0;
        poll_ch.card_detect_level = 1'b1;
        res_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        test_scan_timing();
        test_press_detect();
        test_blink_interval();
        test_random_traffic();

        // drain, then watch a little longer for stray results
        wait_idle();
        repeat (10) @(posedge clk);
        if (poll_outcomes.size() != 0)
        begin
            mismatches += poll_outcomes.size();
            $display("%0d results never arrived", poll_outcomes.size());
        end

        $display("covered %0d polls over %0d blink settings: %0d presses, %0d inserts,",
                 polls_sent, settings, presses, inserts);
        $display("%0d removes, %0d led toggles; %0d results checked, %0d mismatches",
                 removes, toggles, results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
